// ===== hw/rtl/drrs_pkg.sv =====
// ----------------------------------------------------------------------------
// drrs_pkg
// shared types and constants of the deadline read request scheduler
// ----------------------------------------------------------------------------
package drrs_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int SLOT_W    = 8;
	localparam int POS_W     = 8;

	localparam logic [24:0] BLOCK_SIZE_RST = 25'd65536;
	localparam logic [24:0] HOLD_RST       = 25'd50000;
	localparam logic [24:0] DELAY_RST      = 25'd10000;
	localparam logic [31:0] CANCEL_CODE    = 32'h8001008C;

	localparam logic [2:0] MODE_SUBMIT    = 3'd0;
	localparam logic [2:0] MODE_STEP      = 3'd1;
	localparam logic [2:0] MODE_READ_DONE = 3'd2;
	localparam logic [2:0] MODE_ABORT     = 3'd3;
	localparam logic [2:0] MODE_COLLECT   = 3'd4;

	localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
	localparam logic [1:0] CFG_HOLD       = 2'd1;
	localparam logic [1:0] CFG_DELAY      = 2'd2;

	localparam logic [3:0] ST_ACCEPTED  = 4'd0;
	localparam logic [3:0] ST_FULL      = 4'd1;
	localparam logic [3:0] ST_READ_CMD  = 4'd2;
	localparam logic [3:0] ST_DELAY     = 4'd3;
	localparam logic [3:0] ST_IDLE      = 4'd4;
	localparam logic [3:0] ST_COMPLETE  = 4'd5;
	localparam logic [3:0] ST_PENDING   = 4'd6;
	localparam logic [3:0] ST_COLLECTED = 4'd7;
	localparam logic [3:0] ST_INVALID   = 4'd8;
	localparam logic [3:0] ST_ABORT_OK  = 4'd9;
	localparam logic [3:0] ST_CANCELLED = 4'd10;

	typedef enum logic [1:0] {
		CH_NOP,
		CH_INS,
		CH_DEL
	} ch_op_t;

	typedef struct packed {
		ch_op_t              op;
		logic                find_ins;
		logic [POS_W-1:0]    pos;
		logic [SLOT_W-1:0]   slot;
		logic [31:0]         dl;
	} ch_ctl_t;

	typedef struct packed {
		logic                valid;
		logic [SLOT_W-1:0]   slot;
		logic [31:0]         dl;
	} cell_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [39:0] offset;
		logic [31:0] addr;
		logic [30:0] remaining;
		logic [31:0] result;
	} rec_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [3:0]  slot;
		logic [15:0] handle;
		logic [39:0] offset;
		logic [31:0] addr;
		logic [30:0] rlen;
		logic        whole;
		logic [24:0] delay;
		logic        finished;
		logic [31:0] result;
	} res_t;

endpackage

// ===== hw/rtl/deadline_read_request_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// deadline_read_request_scheduler_top
// a result is registered for every accepted transaction; read done also
// deletes the request from its list when the request leaves it; submit
// scans for a free slot, then inserts (one list cell per cycle)
// throughput: one transaction at a time, the next accepted in the cycle after
// the result is registered; reset: lists empty, no command, priority mode
// off, registers at defaults, slot table undefined until written
// ----------------------------------------------------------------------------
module deadline_read_request_scheduler_top #(
	parameter int SLOTS = drrs_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [3:0]         slot_id,
	input  logic [15:0]        file_handle,
	input  logic [39:0]        file_offset,
	input  logic [31:0]        buffer_address,
	input  logic [30:0]        length,
	input  logic               is_timed,
	input  logic [30:0]        time_budget,
	input  logic [31:0]        now,
	input  logic signed [31:0] read_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         status,
	output logic [3:0]         slot_out,
	output logic [15:0]        handle_out,
	output logic [39:0]        offset_out,
	output logic [31:0]        address_out,
	output logic [30:0]        read_length,
	output logic               whole_request,
	output logic [24:0]        delay_time,
	output logic               finished,
	output logic signed [31:0] result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [24:0]        cfg_data
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_FREE,
		S_INS,
		S_EXEC,
		S_DEL,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [24:0] blk_q, hold_q, delay_q;

	// latched transaction
	logic [2:0]  mode_q;
	logic [3:0]  id_q;
	logic [15:0] handle_q;
	logic [39:0] offset_q;
	logic [31:0] addr_q;
	logic [30:0] len_q;
	logic        timed_in_q;
	logic [30:0] tl_q;
	logic [31:0] now_q;
	logic [31:0] rc_q;

	// per-slot flags
	logic [SLOTS-1:0] in_use_q, done_q, cancel_q, timed_q;

	// command and priority state
	logic          cmd_valid_q;
	logic [SW-1:0] cmd_slot_q;
	logic          cmd_whole_q;
	logic [30:0]   cmd_len_q;
	logic          prio_q;
	logic [31:0]   pend_q;

	// work registers
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] sv_slot_q;
	logic          sv_whole_q;
	logic          sv_list_q;
	logic [31:0]   key_dl_q;
	drrs_pkg::res_t res_q, out_q;
	logic          out_valid_q;

	// slot table
	drrs_pkg::rec_t mem [SLOTS];
	drrs_pkg::rec_t rdata_q;
	logic           mem_we;
	logic [SW-1:0]  mem_wa;
	drrs_pkg::rec_t mem_wd;
	logic [SW-1:0]  raddr;

	// lists
	drrs_pkg::ch_ctl_t ctl, imm_ctl, tim_ctl;
	logic [SLOTS-1:0]  imm_hit, tim_hit, hit_sel;
	drrs_pkg::cell_t   imm_head, tim_head;

	drrs_chain #(.SLOTS(SLOTS), .TIMED(1'b0)) u_imm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (imm_ctl),
		.hit    (imm_hit),
		.head   (imm_head)
	);

	drrs_chain #(.SLOTS(SLOTS), .TIMED(1'b1)) u_tim (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tim_ctl),
		.hit    (tim_hit),
		.head   (tim_head)
	);

	// decode helpers
	logic [SW-1:0] id_s, imm_s, tim_s;
	logic [31:0]   tdiff, pdiff;
	logic          overdue, id_bad;

	assign id_s    = SW'(id_q);
	assign imm_s   = SW'(imm_head.slot);
	assign tim_s   = SW'(tim_head.slot);
	assign tdiff   = tim_head.dl - now_q;
	assign pdiff   = pend_q - now_q;
	assign overdue = tim_head.valid && tdiff[31];
	assign id_bad  = (32'(id_q) >= SLOTS) || !in_use_q[id_s];

	always_comb begin
		if (mode_q == drrs_pkg::MODE_STEP) begin
			raddr = (overdue || !imm_head.valid) ? tim_s : imm_s;
		end else if (mode_q == drrs_pkg::MODE_READ_DONE) begin
			raddr = cmd_slot_q;
		end else begin
			raddr = id_s;
		end
	end

	// serve and read done arithmetic
	logic [30:0] sv_len;
	logic        sv_cancel, sv_zero, head_del;
	logic [30:0] new_rem;
	logic        rc_short, rd_fin;
	drrs_pkg::rec_t rd_rec;

	assign sv_cancel = cancel_q[sv_slot_q];
	assign sv_len    = (!sv_whole_q && (rdata_q.remaining > 31'(blk_q))) ?
	                   31'(blk_q) : rdata_q.remaining;
	assign sv_zero   = (sv_len == 31'd0);
	assign head_del  = (state_q == S_EXEC) && (mode_q == drrs_pkg::MODE_STEP) &&
	                   (sv_cancel || sv_zero || sv_whole_q);
	assign new_rem   = rdata_q.remaining - cmd_len_q;
	assign rc_short  = (rc_q != {1'b0, cmd_len_q});

	always_comb begin
		rd_rec = rdata_q;
		if (rc_short) begin
			rd_rec.result = rc_q[31] ? rc_q : (rdata_q.result + rc_q);
			rd_fin        = 1'b1;
		end else begin
			rd_rec.offset    = rdata_q.offset + 40'(cmd_len_q);
			rd_rec.addr      = rdata_q.addr + 32'(cmd_len_q);
			rd_rec.remaining = new_rem;
			rd_rec.result    = rdata_q.result + 32'(cmd_len_q);
			rd_fin           = (new_rem == 31'd0);
		end
	end

	// list control
	logic list_sel, ins_now, del_now;

	assign list_sel = (state_q == S_INS) ? timed_in_q : sv_list_q;
	assign hit_sel  = list_sel ? tim_hit : imm_hit;
	assign ins_now  = (state_q == S_INS) && hit_sel[cnt_q[SW-1:0]];
	assign del_now  = (state_q == S_DEL) && hit_sel[cnt_q[SW-1:0]];

	always_comb begin
		ctl.find_ins = (state_q == S_INS);
		ctl.slot     = drrs_pkg::SLOT_W'(sv_slot_q);
		ctl.dl       = key_dl_q;
		ctl.pos      = (ins_now || del_now) ? drrs_pkg::POS_W'(cnt_q) : '0;
		if (ins_now) begin
			ctl.op = drrs_pkg::CH_INS;
		end else if (del_now || head_del) begin
			ctl.op = drrs_pkg::CH_DEL;
		end else begin
			ctl.op = drrs_pkg::CH_NOP;
		end
		imm_ctl = ctl;
		tim_ctl = ctl;
		if (list_sel) begin
			imm_ctl.op = drrs_pkg::CH_NOP;
		end else begin
			tim_ctl.op = drrs_pkg::CH_NOP;
		end
	end

	// slot table writes
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sv_slot_q;
		mem_wd = rdata_q;
		if (ins_now) begin
			mem_we = 1'b1;
			mem_wd = '{handle: handle_q, offset: offset_q, addr: addr_q,
			           remaining: len_q, result: 32'd0};
		end else if (state_q == S_EXEC && mode_q == drrs_pkg::MODE_STEP && sv_cancel) begin
			mem_we        = 1'b1;
			mem_wd.result = drrs_pkg::CANCEL_CODE;
		end else if (state_q == S_EXEC && mode_q == drrs_pkg::MODE_READ_DONE) begin
			mem_we = 1'b1;
			mem_wd = rd_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[raddr];
	end

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q   <= drrs_pkg::BLOCK_SIZE_RST;
			hold_q  <= drrs_pkg::HOLD_RST;
			delay_q <= drrs_pkg::DELAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				drrs_pkg::CFG_BLOCK_SIZE: blk_q   <= cfg_data;
				drrs_pkg::CFG_HOLD:       hold_q  <= cfg_data;
				drrs_pkg::CFG_DELAY:      delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q     <= mode;
			id_q       <= slot_id;
			handle_q   <= file_handle;
			offset_q   <= file_offset;
			addr_q     <= buffer_address;
			len_q      <= length;
			timed_in_q <= is_timed;
			tl_q       <= time_budget;
			now_q      <= now;
			rc_q       <= read_count;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_use_q    <= '0;
			done_q      <= '0;
			cancel_q    <= '0;
			timed_q     <= '0;
			cmd_valid_q <= 1'b0;
			cmd_slot_q  <= '0;
			cmd_whole_q <= 1'b0;
			cmd_len_q   <= '0;
			prio_q      <= 1'b0;
			pend_q      <= '0;
			cnt_q       <= '0;
			sv_slot_q   <= '0;
			sv_whole_q  <= 1'b0;
			sv_list_q   <= 1'b0;
			key_dl_q    <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DEC;
				end
				S_DEC: begin
					res_q      <= '0;
					sv_slot_q  <= raddr;
					sv_whole_q <= 1'b0;
					state_q    <= S_OUT;
					case (mode_q)
						drrs_pkg::MODE_SUBMIT: begin
							cnt_q    <= '0;
							key_dl_q <= now_q + 32'(tl_q);
							state_q  <= S_FREE;
						end
						drrs_pkg::MODE_STEP: begin
							if (cmd_valid_q) begin
								res_q.status <= drrs_pkg::ST_PENDING;
								res_q.slot   <= 4'(cmd_slot_q);
							end else if (overdue) begin
								sv_whole_q <= 1'b1;
								sv_list_q  <= 1'b1;
								state_q    <= S_EXEC;
							end else if (prio_q) begin
								if ((pdiff != 32'd0) && !pdiff[31]) begin
									res_q.status <= drrs_pkg::ST_DELAY;
									res_q.delay  <= delay_q;
								end else begin
									prio_q       <= 1'b0;
									res_q.status <= drrs_pkg::ST_IDLE;
								end
							end else if (imm_head.valid) begin
								sv_list_q <= 1'b0;
								state_q   <= S_EXEC;
							end else if (tim_head.valid) begin
								sv_list_q <= 1'b1;
								state_q   <= S_EXEC;
							end else begin
								res_q.status <= drrs_pkg::ST_IDLE;
							end
						end
						drrs_pkg::MODE_READ_DONE: begin
							if (cmd_valid_q) begin
								sv_list_q <= timed_q[cmd_slot_q];
								state_q   <= S_EXEC;
							end else begin
								res_q.status <= drrs_pkg::ST_INVALID;
							end
						end
						drrs_pkg::MODE_ABORT: begin
							if (id_bad) begin
								res_q.status <= drrs_pkg::ST_INVALID;
							end else begin
								cancel_q[id_s] <= 1'b1;
								res_q.status   <= drrs_pkg::ST_ABORT_OK;
								res_q.slot     <= id_q;
							end
						end
						drrs_pkg::MODE_COLLECT: begin
							if (id_bad) begin
								res_q.status <= drrs_pkg::ST_INVALID;
							end else if (!done_q[id_s]) begin
								res_q.status <= drrs_pkg::ST_PENDING;
								res_q.slot   <= id_q;
							end else begin
								state_q <= S_EXEC;
							end
						end
						default: res_q.status <= drrs_pkg::ST_INVALID;
					endcase
				end
				S_FREE: begin
					if (cnt_q == CW'(SLOTS)) begin
						res_q.status <= drrs_pkg::ST_FULL;
						state_q      <= S_OUT;
					end else if (!in_use_q[cnt_q[SW-1:0]]) begin
						sv_slot_q <= cnt_q[SW-1:0];
						cnt_q     <= '0;
						state_q   <= S_INS;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_INS: begin
					if (ins_now) begin
						in_use_q[sv_slot_q] <= 1'b1;
						done_q[sv_slot_q]   <= 1'b0;
						cancel_q[sv_slot_q] <= 1'b0;
						timed_q[sv_slot_q]  <= timed_in_q;
						res_q.status        <= drrs_pkg::ST_ACCEPTED;
						res_q.slot          <= 4'(sv_slot_q);
						state_q             <= S_OUT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_EXEC: begin
					res_q.slot <= 4'(sv_slot_q);
					state_q    <= S_OUT;
					case (mode_q)
						drrs_pkg::MODE_STEP: begin
							if (sv_whole_q) begin
								pend_q <= now_q + 32'(hold_q);
								prio_q <= 1'b1;
							end
							if (sv_cancel) begin
								done_q[sv_slot_q] <= 1'b1;
								res_q.status      <= drrs_pkg::ST_CANCELLED;
								res_q.finished    <= 1'b1;
								res_q.result      <= drrs_pkg::CANCEL_CODE;
							end else if (sv_zero) begin
								done_q[sv_slot_q] <= 1'b1;
								res_q.status      <= drrs_pkg::ST_COMPLETE;
								res_q.finished    <= 1'b1;
								res_q.result      <= rdata_q.result;
							end else begin
								cmd_valid_q  <= 1'b1;
								cmd_slot_q   <= sv_slot_q;
								cmd_whole_q  <= sv_whole_q;
								cmd_len_q    <= sv_len;
								res_q.status <= drrs_pkg::ST_READ_CMD;
								res_q.handle <= rdata_q.handle;
								res_q.offset <= rdata_q.offset;
								res_q.addr   <= rdata_q.addr;
								res_q.rlen   <= sv_len;
								res_q.whole  <= sv_whole_q;
							end
						end
						drrs_pkg::MODE_READ_DONE: begin
							cmd_valid_q <= 1'b0;
							cmd_whole_q <= 1'b0;
							if (rd_fin) begin
								done_q[sv_slot_q] <= 1'b1;
								res_q.status      <= drrs_pkg::ST_COMPLETE;
								res_q.finished    <= 1'b1;
								res_q.result      <= rd_rec.result;
								if (!cmd_whole_q) begin
									cnt_q   <= '0;
									state_q <= S_DEL;
								end
							end else begin
								res_q.status <= drrs_pkg::ST_PENDING;
							end
						end
						default: begin
							in_use_q[sv_slot_q] <= 1'b0;
							res_q.status        <= drrs_pkg::ST_COLLECTED;
							res_q.finished      <= 1'b1;
							res_q.result        <= rdata_q.result;
						end
					endcase
				end
				S_DEL: begin
					if (del_now || (cnt_q == CW'(SLOTS - 1))) begin
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign slot_out      = out_q.slot;
	assign handle_out    = out_q.handle;
	assign offset_out    = out_q.offset;
	assign address_out   = out_q.addr;
	assign read_length   = out_q.rlen;
	assign whole_request = out_q.whole;
	assign delay_time    = out_q.delay;
	assign finished      = out_q.finished;
	assign result        = out_q.result;

endmodule

// ===== hw/rtl/drrs_cell.sv =====
// ----------------------------------------------------------------------------
// drrs_cell
// one list position: holds a slot number and its deadline, shifts with its
// neighbors on insert and delete, flags a match for the list search
// ----------------------------------------------------------------------------
module drrs_cell #(
	parameter int IDX   = 0,
	parameter bit TIMED = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  drrs_pkg::ch_ctl_t ctl,
	input  drrs_pkg::cell_t  left,
	input  drrs_pkg::cell_t  right,
	output drrs_pkg::cell_t  q,
	output logic             hit
);

	localparam logic [drrs_pkg::POS_W-1:0] MY_POS = drrs_pkg::POS_W'(IDX);

	logic                        valid_q;
	logic [drrs_pkg::SLOT_W-1:0] slot_q;
	logic [31:0]                 dl_q;
	logic [31:0]                 diff;
	logic                        later;

	assign diff  = dl_q - ctl.dl;
	assign later = (diff != 32'd0) && !diff[31];

	always_comb begin
		if (ctl.find_ins) begin
			hit = !valid_q || (TIMED && later);
		end else begin
			hit = valid_q && (slot_q == ctl.slot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				drrs_pkg::CH_INS: begin
					if (MY_POS == ctl.pos) begin
						valid_q <= 1'b1;
					end else if (MY_POS > ctl.pos) begin
						valid_q <= left.valid;
					end
				end
				drrs_pkg::CH_DEL: begin
					if (MY_POS >= ctl.pos) valid_q <= right.valid;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			drrs_pkg::CH_INS: begin
				if (MY_POS == ctl.pos) begin
					slot_q <= ctl.slot;
					dl_q   <= ctl.dl;
				end else if (MY_POS > ctl.pos) begin
					slot_q <= left.slot;
					dl_q   <= left.dl;
				end
			end
			drrs_pkg::CH_DEL: begin
				if (MY_POS >= ctl.pos) begin
					slot_q <= right.slot;
					dl_q   <= right.dl;
				end
			end
			default: ;
		endcase
	end

	assign q = '{valid: valid_q, slot: slot_q, dl: dl_q};

endmodule

// ===== hw/rtl/drrs_chain.sv =====
// ----------------------------------------------------------------------------
// drrs_chain
// row of list cells forming one ordered request list, head at cell zero
// ----------------------------------------------------------------------------
module drrs_chain #(
	parameter int SLOTS = drrs_pkg::SLOTS_DEF,
	parameter bit TIMED = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  drrs_pkg::ch_ctl_t ctl,
	output logic [SLOTS-1:0]  hit,
	output drrs_pkg::cell_t   head
);

	drrs_pkg::cell_t cq [SLOTS];

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		drrs_pkg::cell_t lft;
		drrs_pkg::cell_t rgt;
		if (i == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid
			assign lft = cq[i-1];
		end
		if (i == SLOTS - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_inner
			assign rgt = cq[i+1];
		end
		drrs_cell #(
			.IDX   (i),
			.TIMED (TIMED)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.left   (lft),
			.right  (rgt),
			.q      (cq[i]),
			.hit    (hit[i])
		);
	end

	assign head = cq[0];

endmodule
